// ===== hw/rtl/efdc_pkg.sv =====
// shared types and constants of the force deviation classifier
package efdc_pkg;

	// register indexes of the configuration port
	localparam logic [1:0] REG_NUM_MODELS = 2'd0;
	localparam logic [1:0] REG_CAND_THR   = 2'd1;
	localparam logic [1:0] REG_FAIL_THR   = 2'd2;

	// reset values of the configuration registers
	localparam logic [2:0]  NUM_MODELS_RST = 3'd4;
	localparam logic [23:0] CAND_THR_RST   = 24'd6554;
	localparam logic [23:0] FAIL_THR_RST   = 24'd16384;

	// frame classes
	localparam logic [1:0] CLASS_SUCCESS   = 2'd0;
	localparam logic [1:0] CLASS_CANDIDATE = 2'd1;
	localparam logic [1:0] CLASS_FAIL      = 2'd2;
	localparam logic [1:0] CLASS_EQUAL     = 2'd3;

	// largest reported norm
	localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEV,
		ST_SQ,
		ST_ACC,
		ST_MAXUP,
		ST_DIV,
		ST_FUP,
		ST_SQRT,
		ST_CLASS
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic dev;
		logic sq;
		logic acc;
		logic maxup;
		logic div_step;
		logic fup;
		logic sqrt_step;
		logic classify;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic close_now;
		logic comp_last;
		logic model_last;
		logic it_done;
		logic last;
		logic out_busy;
	} sts_t;

endpackage

// ===== hw/rtl/efdc_ctrl.sv =====
// sequencer of the force deviation classifier
module efdc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  efdc_pkg::sts_t sts,
	output efdc_pkg::cmd_t cmd
);

	efdc_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efdc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			efdc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.close_now) state_d = efdc_pkg::ST_DEV;
				end
			end
			efdc_pkg::ST_DEV: begin
				cmd.dev = 1'b1;
				state_d = efdc_pkg::ST_SQ;
			end
			efdc_pkg::ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = efdc_pkg::ST_ACC;
			end
			efdc_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.comp_last ? efdc_pkg::ST_MAXUP : efdc_pkg::ST_DEV;
			end
			efdc_pkg::ST_MAXUP: begin
				cmd.maxup = 1'b1;
				state_d = sts.model_last ? efdc_pkg::ST_DIV : efdc_pkg::ST_DEV;
			end
			efdc_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.it_done) state_d = efdc_pkg::ST_FUP;
			end
			efdc_pkg::ST_FUP: begin
				cmd.fup = 1'b1;
				state_d = sts.last ? efdc_pkg::ST_SQRT : efdc_pkg::ST_IDLE;
			end
			efdc_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.it_done) state_d = efdc_pkg::ST_CLASS;
			end
			efdc_pkg::ST_CLASS: begin
				if (!sts.out_busy) begin
					cmd.classify = 1'b1;
					state_d = efdc_pkg::ST_IDLE;
				end
			end
			default: state_d = efdc_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/efdc_datapath.sv =====
// force store, deviation arithmetic, divider, square root and counters
module efdc_datapath #(
	parameter int MAX_MODELS = 4,
	parameter int FORCE_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  efdc_pkg::cmd_t               cmd,
	output efdc_pkg::sts_t               sts,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [23:0]                  cfg_data,
	input  logic signed [FORCE_BITS-1:0] force_x,
	input  logic signed [FORCE_BITS-1:0] force_y,
	input  logic signed [FORCE_BITS-1:0] force_z,
	input  logic                         last_atom,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [23:0]                  max_deviation,
	output logic [1:0]                   frame_class,
	output logic [31:0]                  success_total,
	output logic [31:0]                  candidate_total,
	output logic [31:0]                  fail_total
);

	localparam int CW   = $clog2(MAX_MODELS + 1);
	localparam int SW   = $clog2(MAX_MODELS);
	localparam int NW   = (CW > 3) ? CW : 3;
	localparam int SUMW = FORCE_BITS + CW;
	localparam int DW   = FORCE_BITS + CW + 1;
	localparam int AW   = 24 + CW;
	localparam int CMPW = (DW + 1 > AW) ? DW + 1 : AW;
	localparam int EW   = 2 * AW + 2;
	localparam int RW   = (EW + 1) / 2;
	localparam int XW   = 2 * RW;
	localparam int QW   = 2 * CW;
	localparam int ITW  = $clog2(EW + 1);

	logic [2:0]  nm_q;
	logic [23:0] cand_q, fail_q;

	logic signed [FORCE_BITS-1:0] force_q [MAX_MODELS][3];
	logic signed [SUMW-1:0]       sum_q [3];
	logic [SW-1:0] slot_q, m_q;
	logic [1:0]    c_q;
	logic [CW-1:0] cnt_q;
	logic          last_q;

	logic [AW-1:0]   a_q;
	logic [2*AW-1:0] sq_q;
	logic [EW-1:0]   e_q, emax_q, frame_q;
	logic [EW-1:0]   dq_q;
	logic [QW-1:0]   rem_q;
	logic [XW-1:0]   x_q;
	logic [RW:0]     srem_q;
	logic [RW-1:0]   root_q;
	logic [ITW-1:0]  it_q;
	logic [31:0]     succ_q, candc_q, failc_q;
	logic            ov_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nm_q   <= efdc_pkg::NUM_MODELS_RST;
			cand_q <= efdc_pkg::CAND_THR_RST;
			fail_q <= efdc_pkg::FAIL_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				efdc_pkg::REG_NUM_MODELS: nm_q   <= cfg_data[2:0];
				efdc_pkg::REG_CAND_THR:   cand_q <= cfg_data;
				efdc_pkg::REG_FAIL_THR:   fail_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped model count and atom close decision
	logic [NW-1:0] n_cl, nm_ext;
	logic [CW-1:0] cnt_in;
	always_comb begin
		nm_ext = NW'(nm_q);
		if (nm_ext < NW'(2)) n_cl = NW'(2);
		else if (nm_ext > NW'(MAX_MODELS)) n_cl = NW'(MAX_MODELS);
		else n_cl = nm_ext;
		cnt_in = CW'(slot_q) + CW'(1);
	end
	assign sts.close_now = (NW'(cnt_in) >= n_cl) || last_atom;

	// deviation of one component from the mean, scaled by the count
	logic signed [FORCE_BITS-1:0] fsel;
	logic signed [DW-1:0]         cf;
	logic signed [DW:0]           d;
	logic [DW:0]                  ad;
	logic [AW-1:0]                lim, a_d;
	logic [2*AW-1:0]              sq;
	always_comb begin
		fsel = force_q[m_q][c_q];
		cf   = DW'(signed'({1'b0, cnt_q})) * DW'(fsel);
		d    = (DW+1)'(cf) - (DW+1)'(sum_q[c_q]);
		ad   = d[DW] ? unsigned'(-d) : unsigned'(d);
		lim  = {cnt_q, 24'd0};
		a_d  = (CMPW'(ad) > CMPW'(lim)) ? lim : AW'(ad);
		sq   = a_q * a_q;
	end

	// divider and square root steps
	logic [QW-1:0] dv;
	logic [QW:0]   dt;
	logic          qbit;
	logic [RW+1:0] st, trial;
	logic          rbit;
	logic [EW-1:0] emax_new, frame_new;
	always_comb begin
		dv        = QW'(cnt_q) * QW'(cnt_q);
		dt        = {rem_q, dq_q[EW-1]};
		qbit      = dt >= {1'b0, dv};
		st        = {srem_q[RW-1:0], x_q[XW-1 -: 2]};
		trial     = {root_q, 2'b01};
		rbit      = st >= trial;
		emax_new  = (e_q > emax_q) ? e_q : emax_q;
		frame_new = (dq_q > frame_q) ? dq_q : frame_q;
	end

	// force store, running sums and atom sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			frame_q <= '0;
		end else begin
			if (cmd.load) begin
				slot_q <= sts.close_now ? '0 : SW'(cnt_in);
			end
			if (cmd.fup) begin
				frame_q <= frame_new;
			end
			if (cmd.classify) begin
				frame_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			force_q[slot_q][0] <= force_x;
			force_q[slot_q][1] <= force_y;
			force_q[slot_q][2] <= force_z;
			sum_q[0] <= ((slot_q == '0) ? '0 : sum_q[0]) + SUMW'(force_x);
			sum_q[1] <= ((slot_q == '0) ? '0 : sum_q[1]) + SUMW'(force_y);
			sum_q[2] <= ((slot_q == '0) ? '0 : sum_q[2]) + SUMW'(force_z);
			cnt_q  <= cnt_in;
			last_q <= last_atom;
			m_q    <= '0;
			c_q    <= '0;
			e_q    <= '0;
			emax_q <= '0;
		end
		if (cmd.dev) a_q <= a_d;
		if (cmd.sq) sq_q <= sq;
		if (cmd.acc) begin
			e_q <= e_q + EW'(sq_q);
			c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
		end
		if (cmd.maxup) begin
			emax_q <= emax_new;
			e_q    <= '0;
			m_q    <= m_q + SW'(1);
			// load the divider with the atom maximum
			dq_q  <= emax_new;
			rem_q <= '0;
			it_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? QW'(dt - {1'b0, dv}) : QW'(dt);
			dq_q  <= {dq_q[EW-2:0], qbit};
			it_q  <= it_q + ITW'(1);
		end
		if (cmd.fup) begin
			x_q    <= XW'(frame_new);
			srem_q <= '0;
			root_q <= '0;
			it_q   <= '0;
		end
		if (cmd.sqrt_step) begin
			srem_q <= rbit ? (RW+1)'(st - trial) : (RW+1)'(st);
			root_q <= {root_q[RW-2:0], rbit};
			x_q    <= {x_q[XW-3:0], 2'b00};
			it_q   <= it_q + ITW'(1);
		end
	end

	assign sts.comp_last  = (c_q == 2'd2);
	assign sts.model_last = (m_q == SW'(cnt_q - CW'(1)));
	assign sts.it_done    = cmd.div_step ? (it_q == ITW'(EW - 1)) : (it_q == ITW'(RW - 1));
	assign sts.last       = last_q;
	assign sts.out_busy   = ov_q && !out_ready;

	// classification against the thresholds
	logic [23:0] v;
	logic [1:0]  cls;
	always_comb begin
		v = (root_q > RW'(efdc_pkg::OUT_MAX)) ? efdc_pkg::OUT_MAX : root_q[23:0];
		if (v > cand_q && v < fail_q) cls = efdc_pkg::CLASS_CANDIDATE;
		else if (v > fail_q) cls = efdc_pkg::CLASS_FAIL;
		else if (v < cand_q) cls = efdc_pkg::CLASS_SUCCESS;
		else cls = efdc_pkg::CLASS_EQUAL;
	end

	// saturating counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			succ_q  <= '0;
			candc_q <= '0;
			failc_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			ov_q <= cmd.classify || (ov_q && !out_ready);
			if (cmd.classify) begin
				if (cls == efdc_pkg::CLASS_SUCCESS && succ_q != '1) succ_q <= succ_q + 32'd1;
				if (cls == efdc_pkg::CLASS_CANDIDATE && candc_q != '1)
					candc_q <= candc_q + 32'd1;
				if (cls == efdc_pkg::CLASS_FAIL && failc_q != '1) failc_q <= failc_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			max_deviation <= v;
			frame_class   <= cls;
		end
	end

	assign out_valid       = ov_q;
	assign success_total   = succ_q;
	assign candidate_total = candc_q;
	assign fail_total      = failc_q;

endmodule

// ===== hw/rtl/ensemble_force_deviation_classifier_unit.sv =====
// top level of the ensemble force deviation classifier
//
// Input beats carry one model's force vector (signed Q8.16) of one atom; the
// models of an atom come in order, and last_atom marks the frame's last beat.
// The block takes one beat at a time: a beat that does not close an atom is
// stored and the block stays ready. Closing an atom of n models runs deviation
// work for each model (each component in turn through deviation, square and
// accumulate steps on the squarer, plus a max update), then the bit-serial
// divider and one update step. On a frame's last beat the square root follows,
// one result bit per cycle, then a class step classes the frame.
// One result beat per frame leaves through the output register, with the
// norm, class and saturating success, candidate and fail totals.
// If the receiver stalls, a finished result waits in the output register; the
// block keeps taking beats and stalls only when a second result is ready.
// Configuration writes take effect at once and belong in idle time.
// Reset clears the counters, the frame maximum and the model slot and loads
// the register defaults; the force store is not cleared.
module ensemble_force_deviation_classifier_unit #(
	parameter int MAX_MODELS = 4,
	parameter int FORCE_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [23:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [FORCE_BITS-1:0] force_x,
	input  logic signed [FORCE_BITS-1:0] force_y,
	input  logic signed [FORCE_BITS-1:0] force_z,
	input  logic                         last_atom,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [23:0]                  max_deviation,
	output logic [1:0]                   frame_class,
	output logic [31:0]                  success_total,
	output logic [31:0]                  candidate_total,
	output logic [31:0]                  fail_total
);

	efdc_pkg::cmd_t cmd;
	efdc_pkg::sts_t sts;

	// sequencer
	efdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and storage
	efdc_datapath #(
		.MAX_MODELS (MAX_MODELS),
		.FORCE_BITS (FORCE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.force_x         (force_x),
		.force_y         (force_y),
		.force_z         (force_z),
		.last_atom       (last_atom),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.max_deviation   (max_deviation),
		.frame_class     (frame_class),
		.success_total   (success_total),
		.candidate_total (candidate_total),
		.fail_total      (fail_total)
	);

	// a classed frame always shows its own counter moved, and a failed frame a nonzero norm
	a_succ_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_class == efdc_pkg::CLASS_SUCCESS |-> success_total != 32'd0)
		else $error("success frame with zero success total");

	a_cand_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_class == efdc_pkg::CLASS_CANDIDATE |-> candidate_total != 32'd0)
		else $error("candidate frame with zero candidate total");

	a_fail_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_class == efdc_pkg::CLASS_FAIL |->
		fail_total != 32'd0 && max_deviation != 24'd0)
		else $error("fail frame with zero fail total or zero norm");

endmodule
